// ===== rtl/core/calculator_program_splitter_macros.svh =====
// Assertion macros shared by the splitter checker.
// Each macro wraps one clocked, reset-qualified concurrent assertion.
`ifndef CALCULATOR_PROGRAM_SPLITTER_MACROS_SVH
`define CALCULATOR_PROGRAM_SPLITTER_MACROS_SVH

// property holds on every edge outside reset
`define CPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("splitter assertion failed");

// consequent holds in the cycle after the antecedent
`define CPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("splitter sequence assertion failed");

`endif

// ===== rtl/core/cps_pkg.sv =====
// Types and constants of the calculator program splitter.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package cps_pkg;

  typedef enum logic [1:0] {
    PH_START   = 2'd0,
    PH_BODY    = 2'd1,
    PH_CSECOND = 2'd2,
    PH_CTHIRD  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    K_SINGLE = 3'd0,
    K_TWO    = 3'd1,
    K_THREE  = 3'd2,
    K_LABEL  = 3'd3,
    K_END    = 3'd4,
    K_STRING = 3'd5
  } kind_e;

  localparam int unsigned DATA_W = 24;
  localparam int unsigned USER_W = 5;
  localparam int unsigned IDX_W  = 16;

  // opcode range bounds
  localparam logic [7:0] OP_TWO_LO   = 8'h90;
  localparam logic [7:0] OP_LBL_LO   = 8'hc0;
  localparam logic [7:0] OP_LBL_HI   = 8'hcd;
  localparam logic [7:0] OP_THREE_LO = 8'hd0;
  localparam logic [7:0] OP_STR_LO   = 8'hf0;

  // third-byte flags of a label/end
  localparam logic [7:0] FLAG_LABEL  = 8'h80;
  localparam logic [7:0] FLAG_GLOBAL = 8'h20;
  localparam logic [3:0] NIBBLE_MASK = 4'hf;

endpackage

// ===== rtl/core/calculator_program_splitter.sv =====
// Calculator program splitter: tags each program byte with instruction boundaries.
// Depends on cps_pkg.
`timescale 1ns / 1ps

//  channel  | dir | tdata                                  | tuser / tlast
//  s_axis   | in  | [7:0] code_byte                        | -
//  m_axis   | out | [7:0] byte_value, [23:8] program_index | tuser [0] instr_start,
//           |     |                                        | [3:1] instr_kind,
//           |     |                                        | [4] memory_end; tlast program_end
//
// One byte per cycle while m_axis accepts; each accepted byte appears on m_axis in the next cycle.
// The decode state updates in the accept cycle, so throughput is set by the
// single output register: s_axis_tready follows !m_axis_tvalid || m_axis_tready.
// After the global end, bytes are still accepted but dropped until reset.
// Reset (rst_ni low, async) returns to instruction-start, program index zero.

module calculator_program_splitter #(
  parameter int unsigned PROG_INDEX_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] code_byte
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [cps_pkg::DATA_W-1:0] m_axis_tdata,   // [7:0] byte_value, [23:8] program_index
  output logic [cps_pkg::USER_W-1:0] m_axis_tuser,   // [0] instr_start, [3:1] kind, [4] memory_end
  output logic                       m_axis_tlast    // program_end
);
  import cps_pkg::*;

  localparam int unsigned CW = PROG_INDEX_BITS;

  phase_e           phase_q, phase_d;
  logic [3:0]       left_q, left_d;
  kind_e            kind_q, kind_d;
  logic [CW-1:0]    count_q, count_d;
  logic             fin_q, fin_d;

  logic             out_valid_q, out_valid_d;
  logic [DATA_W-1:0] tdata_q, tdata_d;
  logic [USER_W-1:0] tuser_q, tuser_d;
  logic             tlast_q, tlast_d;

  logic             take;
  logic [32:0]      count_ext;
  logic [IDX_W-1:0] idx;
  logic [7:0]       b;
  kind_e            res_kind;
  logic             res_start, pend, mend;
  logic [3:0]       left_dec;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready && !fin_q;
  assign b             = s_axis_tdata;

  // saturate wide counters into the 16-bit index
  assign count_ext = 33'(count_q);
  assign idx       = (|count_ext[32:IDX_W]) ? '1 : count_ext[IDX_W-1:0];
  assign left_dec  = (left_q != 4'd0) ? left_q - 4'd1 : left_q;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    kind_d    = kind_q;
    count_d   = count_q;
    fin_d     = fin_q;
    res_kind  = kind_q;
    res_start = 1'b0;
    pend      = 1'b0;
    mend      = 1'b0;
    if (take) begin
      unique case (phase_q)
        PH_BODY: begin
          left_d = left_dec;
          if (left_dec == 4'd0) begin
            phase_d = PH_START;
          end
        end
        PH_CSECOND: begin
          phase_d = PH_CTHIRD;
        end
        PH_CTHIRD: begin
          priority if ((b & FLAG_LABEL) != 8'd0) begin
            res_kind = K_LABEL;
            left_d   = b[3:0] & NIBBLE_MASK;
            phase_d  = ((b[3:0] & NIBBLE_MASK) != 4'd0) ? PH_BODY : PH_START;
          end else if ((b & FLAG_GLOBAL) != 8'd0) begin
            res_kind = K_END;
            mend     = 1'b1;
            fin_d    = 1'b1;
            phase_d  = PH_START;
          end else begin
            res_kind = K_END;
            pend     = 1'b1;
            if (count_q != '1) begin
              count_d = count_q + CW'(1);
            end
            phase_d  = PH_START;
          end
          kind_d = res_kind;
        end
        PH_START: begin
          res_start = 1'b1;
          priority if (b < OP_TWO_LO) begin
            res_kind = K_SINGLE;
            phase_d  = PH_START;
          end else if (b < OP_LBL_LO) begin
            res_kind = K_TWO;
            left_d   = 4'd1;
            phase_d  = PH_BODY;
          end else if (b <= OP_LBL_HI) begin
            res_kind = K_LABEL;
            phase_d  = PH_CSECOND;
          end else if (b < OP_THREE_LO) begin
            res_kind = K_TWO;
            left_d   = 4'd1;
            phase_d  = PH_BODY;
          end else if (b < OP_STR_LO) begin
            res_kind = K_THREE;
            left_d   = 4'd2;
            phase_d  = PH_BODY;
          end else begin
            res_kind = K_STRING;
            left_d   = b[3:0] & NIBBLE_MASK;
            phase_d  = ((b[3:0] & NIBBLE_MASK) != 4'd0) ? PH_BODY : PH_START;
          end
          kind_d = res_kind;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    tdata_d     = tdata_q;
    tuser_d     = tuser_q;
    tlast_d     = tlast_q;
    if (take) begin
      out_valid_d = 1'b1;
      tdata_d     = {idx, b};
      tuser_d     = {mend, res_kind, res_start};
      tlast_d     = pend;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      left_q      <= 4'd0;
      kind_q      <= K_SINGLE;
      count_q     <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      kind_q      <= kind_d;
      count_q     <= count_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdata_q <= tdata_d;
    tuser_q <= tuser_d;
    tlast_q <= tlast_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

endmodule

// ===== rtl/core/cps_checker.sv =====
// Port-level checks for the calculator program splitter, bound to the top level.
// Depends on cps_pkg and calculator_program_splitter_macros.svh.
`timescale 1ns / 1ps
`include "calculator_program_splitter_macros.svh"

module cps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [cps_pkg::DATA_W-1:0] m_axis_tdata,
  input logic [cps_pkg::USER_W-1:0] m_axis_tuser,
  input logic                       m_axis_tlast
);
  import cps_pkg::*;

  logic                     stalled;
  logic [DATA_W+USER_W:0]   out_word;
  logic                     end_word;
  logic                     pend_ok;
  logic                     end_taken;

  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign end_word  = (m_axis_tuser[3:1] == K_END) && !m_axis_tuser[0];
  assign pend_ok   = end_word && !m_axis_tuser[4];
  assign end_taken = m_axis_tvalid && m_axis_tready && m_axis_tuser[4];

  // stalled word holds
  `CPS_ASSERT_NEXT(a_hold, clk_i, rst_ni, stalled, m_axis_tvalid && $stable(out_word))

  // a global end word is always of end kind
  `CPS_ASSERT(a_mend_kind, clk_i, rst_ni, !(m_axis_tvalid && m_axis_tuser[4]) || end_word)

  // local end closes on a non-start end word, never together with global end
  `CPS_ASSERT(a_pend_kind, clk_i, rst_ni, !(m_axis_tvalid && m_axis_tlast) || pend_ok)

  // nothing follows the global end
  `CPS_ASSERT_NEXT(a_after_end, clk_i, rst_ni, end_taken, !m_axis_tvalid)

endmodule

bind calculator_program_splitter cps_checker u_cps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
